[hdl/clcc_pkg.sv]
// ----------------------------------------------------------------------------
// clcc_pkg
// Shared types and constants for the centroid line-crossing counter.
// ----------------------------------------------------------------------------
`default_nettype none

package clcc_pkg;

  // fixed field widths
  localparam int unsigned REG_W      = 12;
  localparam int unsigned BOX_W      = 12;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned NET_W      = 16;
  localparam int unsigned ACT_W      = 3;
  localparam int unsigned CRS_W      = 2;
  localparam int unsigned TRK_W      = 5;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_ZONE_LEFT  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ZONE_RIGHT = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_CROSS_LINE = 2'd2;

  localparam logic [REG_W-1:0] ZONE_LEFT_RST  = 12'd40;
  localparam logic [REG_W-1:0] ZONE_RIGHT_RST = 12'd160;
  localparam logic [REG_W-1:0] CROSS_LINE_RST = 12'd80;

  // result action codes
  localparam logic [ACT_W-1:0] ACT_UPDATED = 3'd0;
  localparam logic [ACT_W-1:0] ACT_DROPPED = 3'd1;
  localparam logic [ACT_W-1:0] ACT_ADDED   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_IGNORED = 3'd3;
  localparam logic [ACT_W-1:0] ACT_FULL    = 3'd4;

  // crossing codes
  localparam logic signed [CRS_W-1:0] CROSS_NONE  = 2'sd0;
  localparam logic signed [CRS_W-1:0] CROSS_RIGHT = 2'sd1;
  localparam logic signed [CRS_W-1:0] CROSS_LEFT  = -2'sd1;

  localparam logic signed [NET_W-1:0] NET_MAX = 16'sh7FFF;
  localparam logic signed [NET_W-1:0] NET_MIN = 16'sh8000;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic setup;
    logic scan;
    logic decide;
    logic shift;
  } clcc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic drop_shift;
    logic shift_done;
  } clcc_stat_t;

endpackage

`default_nettype wire

[hdl/clcc_ram.sv]
// ----------------------------------------------------------------------------
// clcc_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module clcc_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[hdl/clcc_ctrl.sv]
// ----------------------------------------------------------------------------
// clcc_ctrl
// Sequencer: accept, radius setup, table scan, decision and table compaction.
// ----------------------------------------------------------------------------
`default_nettype none

module clcc_ctrl import clcc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_tvalid_i,
  output logic            s_tready_o,
  output logic            m_tvalid_o,
  input  wire logic       m_tready_i,
  input  wire clcc_stat_t stat_i,
  output clcc_cmd_t       cmd_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SETUP  = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_DECIDE = 3'd3;
  localparam logic [2:0] ST_SHIFT  = 3'd4;

  logic [2:0] state_q, state_d;
  logic       mvalid_q, mvalid_d;
  logic       out_free;

  assign out_free   = !mvalid_q || m_tready_i;
  assign s_tready_o = (state_q == ST_IDLE);
  assign m_tvalid_o = mvalid_q;

  always_comb begin
    state_d  = state_q;
    mvalid_d = mvalid_q && !m_tready_i;
    cmd_o    = '0;
    case (state_q)
      ST_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_done) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        // the result register must be free before the table is touched
        if (out_free) begin
          cmd_o.decide = 1'b1;
          mvalid_d     = 1'b1;
          state_d      = stat_i.drop_shift ? ST_SHIFT : ST_IDLE;
        end
      end
      ST_SHIFT: begin
        cmd_o.shift = 1'b1;
        if (stat_i.shift_done) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      mvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      mvalid_q <= mvalid_d;
    end
  end

endmodule

`default_nettype wire

[hdl/clcc_dp.sv]
// ----------------------------------------------------------------------------
// clcc_dp
// Datapath: zone registers, distance pipeline, match capture, table update,
// saturating net count and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module clcc_dp import clcc_pkg::*; #(
  parameter int unsigned MAX_TRACKS = 16,
  parameter int unsigned COORD_BITS = 12,
  localparam int unsigned IDX_W = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1,
  localparam int unsigned CNT_W = $clog2(MAX_TRACKS + 1),
  localparam int unsigned ENT_W = 2 * COORD_BITS
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire clcc_cmd_t               cmd_i,
  output clcc_stat_t                   stat_o,
  input  wire logic                    cfg_we_i,
  input  wire logic [CFG_ADDR_W-1:0]   cfg_addr_i,
  input  wire logic [REG_W-1:0]        cfg_wdata_i,
  input  wire logic [COORD_BITS-1:0]   blob_x_i,
  input  wire logic [COORD_BITS-1:0]   blob_y_i,
  input  wire logic [BOX_W-1:0]        box_width_i,
  input  wire logic [BOX_W-1:0]        box_height_i,
  output logic      [IDX_W-1:0]        ram_raddr_o,
  input  wire logic [ENT_W-1:0]        ram_rdata_i,
  output logic                         ram_we_o,
  output logic      [IDX_W-1:0]        ram_waddr_o,
  output logic      [ENT_W-1:0]        ram_wdata_o,
  output logic signed [NET_W-1:0]      people_total_o,
  output logic      [ACT_W-1:0]        action_o,
  output logic signed [CRS_W-1:0]      crossing_o,
  output logic      [TRK_W-1:0]        tracks_in_use_o
);

  localparam int unsigned CW    = (COORD_BITS > REG_W) ? COORD_BITS : REG_W;
  localparam int unsigned SQ_W  = 2 * COORD_BITS;
  localparam int unsigned D2_W  = SQ_W + 1;
  localparam int unsigned R2_W  = 2 * BOX_W;
  localparam int unsigned CMP_W = (D2_W > R2_W) ? D2_W : R2_W;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TRACKS);

  // configuration
  logic [REG_W-1:0] zl_q, zr_q, cl_q;

  // item under work
  logic [COORD_BITS-1:0] bx_q, by_q;
  logic [BOX_W-1:0]      r_q;
  logic [R2_W-1:0]       r2_q;
  logic [BOX_W-1:0]      half_w, half_h, lim;

  // table state
  logic [CNT_W-1:0]        count_q, count_d;
  logic signed [NET_W-1:0] net_q, net_d;
  logic [CNT_W-1:0]        ptr_q;

  // distance pipeline
  logic                  v1_q, v2_q, v3_q, v4_q;
  logic [IDX_W-1:0]      idx1_q, idx2_q, idx3_q, idx4_q;
  logic [COORD_BITS-1:0] tx2_q, tx3_q, tx4_q;
  logic [COORD_BITS-1:0] rd_x, rd_y, adx_d, ady_d, adx_q, ady_q;
  logic [SQ_W-1:0]       sqx_q, sqy_q;
  logic [D2_W-1:0]       d2_q;
  logic                  near;

  // match capture
  logic                  match_q;
  logic [IDX_W-1:0]      match_idx_q;
  logic [COORD_BITS-1:0] match_ox_q;
  logic [CNT_W-1:0]      match_next;

  // compaction
  logic             sh_v_q;
  logic [IDX_W-1:0] sh_waddr_q;

  logic                    scan_issue, shift_issue, pipe_busy;
  logic                    in_zone;
  logic [CW-1:0]           bx_ext, ox_ext, cl_ext;
  logic signed [CRS_W-1:0] cross_d;
  logic [ACT_W-1:0]        act_d;

  // payload of the result register
  logic signed [NET_W-1:0] people_q;
  logic [ACT_W-1:0]        act_q;
  logic signed [CRS_W-1:0] crs_q;
  logic [TRK_W-1:0]        trk_q;

  assign half_w = box_width_i >> 1;
  assign half_h = box_height_i >> 1;
  assign lim    = (half_w < half_h) ? half_w : half_h;

  assign rd_x  = ram_rdata_i[COORD_BITS-1:0];
  assign rd_y  = ram_rdata_i[ENT_W-1:COORD_BITS];
  assign adx_d = (bx_q > rd_x) ? (bx_q - rd_x) : (rd_x - bx_q);
  assign ady_d = (by_q > rd_y) ? (by_q - rd_y) : (rd_y - by_q);
  assign near  = CMP_W'(d2_q) < CMP_W'(r2_q);

  assign scan_issue  = cmd_i.scan && !match_q && (ptr_q < count_q);
  assign pipe_busy   = v1_q || v2_q || v3_q || v4_q;
  assign shift_issue = cmd_i.shift && (ptr_q <= count_q);
  assign match_next  = CNT_W'(match_idx_q) + CNT_W'(1);

  assign bx_ext  = CW'(bx_q);
  assign ox_ext  = CW'(match_ox_q);
  assign cl_ext  = CW'(cl_q);
  assign in_zone = (bx_ext >= CW'(zl_q)) && (bx_ext <= CW'(zr_q));

  assign stat_o.scan_done  = !scan_issue && !pipe_busy;
  assign stat_o.drop_shift = match_q && !in_zone && (match_next < count_q);
  assign stat_o.shift_done = !shift_issue && !sh_v_q;

  assign ram_raddr_o = ptr_q[IDX_W-1:0];

  // crossing rule against the matched entry's old x
  always_comb begin
    cross_d = CROSS_NONE;
    if (match_q && in_zone) begin
      if (bx_ext >= cl_ext && ox_ext < cl_ext) begin
        cross_d = CROSS_RIGHT;
      end else if (bx_ext <= cl_ext && ox_ext > cl_ext) begin
        cross_d = CROSS_LEFT;
      end
    end
  end

  always_comb begin
    count_d = count_q;
    net_d   = net_q;
    act_d   = ACT_IGNORED;
    if (match_q) begin
      if (in_zone) begin
        act_d = ACT_UPDATED;
        if (cross_d == CROSS_RIGHT && net_q != NET_MAX) begin
          net_d = net_q + 16'sd1;
        end else if (cross_d == CROSS_LEFT && net_q != NET_MIN) begin
          net_d = net_q - 16'sd1;
        end
      end else begin
        act_d   = ACT_DROPPED;
        count_d = count_q - CNT_W'(1);
      end
    end else if (in_zone) begin
      if (count_q < MAX_CNT) begin
        act_d   = ACT_ADDED;
        count_d = count_q + CNT_W'(1);
      end else begin
        act_d = ACT_FULL;
      end
    end
  end

  // table write port: update, append, or one compaction move
  always_comb begin
    ram_we_o    = 1'b0;
    ram_waddr_o = sh_waddr_q;
    ram_wdata_o = ram_rdata_i;
    if (cmd_i.decide && match_q && in_zone) begin
      ram_we_o    = 1'b1;
      ram_waddr_o = match_idx_q;
      ram_wdata_o = {by_q, bx_q};
    end else if (cmd_i.decide && !match_q && in_zone && count_q < MAX_CNT) begin
      ram_we_o    = 1'b1;
      ram_waddr_o = count_q[IDX_W-1:0];
      ram_wdata_o = {by_q, bx_q};
    end else if (sh_v_q) begin
      ram_we_o = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zl_q    <= ZONE_LEFT_RST;
      zr_q    <= ZONE_RIGHT_RST;
      cl_q    <= CROSS_LINE_RST;
      count_q <= '0;
      net_q   <= '0;
      ptr_q   <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      match_q <= 1'b0;
      sh_v_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_ZONE_LEFT:  zl_q <= cfg_wdata_i;
          REG_ZONE_RIGHT: zr_q <= cfg_wdata_i;
          REG_CROSS_LINE: cl_q <= cfg_wdata_i;
          default: ;
        endcase
      end

      if (cmd_i.load) begin
        ptr_q <= '0;
      end else if (scan_issue || shift_issue) begin
        ptr_q <= ptr_q + CNT_W'(1);
      end else if (cmd_i.decide) begin
        ptr_q <= match_next;
      end

      v1_q   <= scan_issue;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      v4_q   <= v3_q;
      sh_v_q <= shift_issue;

      if (cmd_i.load) begin
        match_q <= 1'b0;
      end else if (v4_q && near && !match_q) begin
        match_q <= 1'b1;
      end

      if (cmd_i.decide) begin
        count_q <= count_d;
        net_q   <= net_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      bx_q <= blob_x_i;
      by_q <= blob_y_i;
      r_q  <= lim + BOX_W'(1);
    end
    if (cmd_i.setup) begin
      r2_q <= R2_W'(r_q) * R2_W'(r_q);
    end

    idx1_q <= ptr_q[IDX_W-1:0];
    idx2_q <= idx1_q;
    idx3_q <= idx2_q;
    idx4_q <= idx3_q;
    tx2_q  <= rd_x;
    tx3_q  <= tx2_q;
    tx4_q  <= tx3_q;
    adx_q  <= adx_d;
    ady_q  <= ady_d;
    sqx_q  <= SQ_W'(adx_q) * SQ_W'(adx_q);
    sqy_q  <= SQ_W'(ady_q) * SQ_W'(ady_q);
    d2_q   <= D2_W'(sqx_q) + D2_W'(sqy_q);

    if (v4_q && near && !match_q) begin
      match_idx_q <= idx4_q;
      match_ox_q  <= tx4_q;
    end

    // read address ptr, the entry below it takes the data next cycle
    sh_waddr_q <= IDX_W'(ptr_q - CNT_W'(1));

    if (cmd_i.decide) begin
      people_q <= net_d;
      act_q    <= act_d;
      crs_q    <= cross_d;
      trk_q    <= TRK_W'(count_d);
    end
  end

  assign people_total_o  = people_q;
  assign action_o        = act_q;
  assign crossing_o      = crs_q;
  assign tracks_in_use_o = trk_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MAX_CNT)
    else $error("track count above table size");

  a_match_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.decide && match_q |-> CNT_W'(match_idx_q) < count_q)
    else $error("matched entry outside occupied table");

  a_net_only_on_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.decide |=> $stable(net_q))
    else $error("net count moved outside decision");

  a_shift_below_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sh_v_q |-> CNT_W'(sh_waddr_q) < count_q)
    else $error("compaction writes beyond occupied table");
`endif

endmodule

`default_nettype wire

[hdl/centroid_line_crossing_counter_core.sv]
// ----------------------------------------------------------------------------
// centroid_line_crossing_counter_core
// Blob-to-track matcher with a saturating line-crossing people counter.
// ----------------------------------------------------------------------------
// One blob is worked on at a time. A setup state squares the match radius,
// then the table scan issues one entry per cycle into a four-stage distance
// pipeline (abs difference, squares, sum, compare) and waits for the pipeline
// to empty; a decision state then updates the table and count once the output
// register is free. A match at index m stops the scan early, after the
// pipeline has resolved entry m. A blob that matches outside the zone then
// compacts the table through the memory's read and write ports, one entry per
// cycle. A full table holds 16 entries with the default MAX_TRACKS.
// Results sit in an output register, so a new blob is taken while the
// previous result waits. Track entries come up undefined after reset and are
// never read beyond the occupied count; no clearing pass is needed.
`default_nettype none

module centroid_line_crossing_counter_core import clcc_pkg::*; #(
  parameter int unsigned MAX_TRACKS = 16,
  parameter int unsigned COORD_BITS = 12,
  localparam int unsigned IN_W        = 2 * COORD_BITS + 2 * BOX_W,
  localparam int unsigned IN_TDATA_W  = ((IN_W + 7) / 8) * 8,
  localparam int unsigned OUT_W       = NET_W + ACT_W + CRS_W + TRK_W,
  localparam int unsigned OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // blob_x, blob_y, box_width, box_height
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // people_total, action, crossing, tracks_in_use
  output logic      [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_ADDR_W-1:0]  cfg_addr_i,
  input  wire logic [REG_W-1:0]       cfg_wdata_i
);

  localparam int unsigned IDX_W = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int unsigned ENT_W = 2 * COORD_BITS;

  clcc_cmd_t  cmd;
  clcc_stat_t stat;

  logic [COORD_BITS-1:0]   blob_x, blob_y;
  logic [BOX_W-1:0]        box_width, box_height;
  logic [IDX_W-1:0]        ram_raddr, ram_waddr;
  logic [ENT_W-1:0]        ram_rdata, ram_wdata;
  logic                    ram_we;
  logic signed [NET_W-1:0] people_total;
  logic [ACT_W-1:0]        action;
  logic signed [CRS_W-1:0] crossing;
  logic [TRK_W-1:0]        tracks_in_use;

  assign blob_x     = s_axis_tdata[COORD_BITS-1:0];
  assign blob_y     = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
  assign box_width  = s_axis_tdata[2*COORD_BITS+BOX_W-1:2*COORD_BITS];
  assign box_height = s_axis_tdata[IN_W-1:2*COORD_BITS+BOX_W];

  assign m_axis_tdata = OUT_TDATA_W'({tracks_in_use, crossing, action, people_total});

  clcc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  clcc_dp #(
    .MAX_TRACKS (MAX_TRACKS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .blob_x_i        (blob_x),
    .blob_y_i        (blob_y),
    .box_width_i     (box_width),
    .box_height_i    (box_height),
    .ram_raddr_o     (ram_raddr),
    .ram_rdata_i     (ram_rdata),
    .ram_we_o        (ram_we),
    .ram_waddr_o     (ram_waddr),
    .ram_wdata_o     (ram_wdata),
    .people_total_o  (people_total),
    .action_o        (action),
    .crossing_o      (crossing),
    .tracks_in_use_o (tracks_in_use)
  );

  // track table, x in the low half and y in the high half of each entry
  clcc_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_TRACKS)
  ) u_track_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire

[test/centroid_line_crossing_counter_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// centroid_line_crossing_counter_core_tb
// Streams blobs into the crossing counter and checks every result against a
// local tracker that keeps its own track table, zone registers and net count.
// Directed tests cover crossings, drops, zero-size boxes, field extremes, a
// full table, an inverted zone and runs of crossings both ways; random phases
// follow under several zone settings with random idling on both sides.
// ----------------------------------------------------------------------------

module centroid_line_crossing_counter_core_tb;
  import clcc_pkg::*;

  localparam int unsigned COORD_W     = 12;
  localparam int unsigned MAX_TRACKS  = 16;
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_W       = NET_W + ACT_W + CRS_W + TRK_W;
  localparam int unsigned OUT_TDATA_W = 32;
  localparam int unsigned COORD_TOP   = 4095;
  localparam int unsigned SETTLE_CYC  = 60;

  // first declared field sits in the top bits
  typedef struct packed {
    logic [BOX_W-1:0]   box_height;
    logic [BOX_W-1:0]   box_width;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } blob_t;

  typedef struct packed {
    logic [TRK_W-1:0] tracks;
    logic [CRS_W-1:0] crossing;
    logic [ACT_W-1:0] action;
    logic [NET_W-1:0] total;
  } count_report_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  // blob_x, blob_y, box_width, box_height
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  // people_total, action, crossing, tracks_in_use
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic                   cfg_we_i;
  logic [CFG_ADDR_W-1:0]  cfg_addr_i;
  logic [REG_W-1:0]       cfg_wdata_i;

  // tracker state
  logic [COORD_W-1:0]     trk_x [MAX_TRACKS];
  logic [COORD_W-1:0]     trk_y [MAX_TRACKS];
  int unsigned            track_count;
  logic signed [NET_W-1:0] net_total;
  logic [REG_W-1:0]       cfg_left;
  logic [REG_W-1:0]       cfg_right;
  logic [REG_W-1:0]       cfg_line;

  count_report_t          expected_reports[$];
  int                     error_count    = 0;
  int unsigned            src_gap_max    = 6;
  int unsigned            sink_stall_max = 6;
  int unsigned            sink_hold      = 0;

  centroid_line_crossing_counter_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #10 clk_i = ~clk_i;

  function automatic logic [COORD_W-1:0] clamp_coord(input int v);
    if (v < 0) return '0;
    if (v > int'(COORD_TOP)) return COORD_W'(COORD_TOP);
    return COORD_W'(v);
  endfunction

  function automatic bit zone_has(input logic [COORD_W-1:0] x);
    return x >= cfg_left && x <= cfg_right;
  endfunction

  // match, update or append one blob and queue the result it should give
  task automatic predict_tracking(input blob_t b);
    count_report_t r;
    logic [BOX_W-1:0] lim;
    int unsigned dx, dy, rad;
    int hit, i;
    hit = -1;
    lim = ((b.box_width >> 1) < (b.box_height >> 1)) ? (b.box_width >> 1)
                                                     : (b.box_height >> 1);
    rad = lim + 1;
    for (i = 0; i < int'(track_count); i++) begin
      dx = (b.x > trk_x[i]) ? b.x - trk_x[i] : trk_x[i] - b.x;
      dy = (b.y > trk_y[i]) ? b.y - trk_y[i] : trk_y[i] - b.y;
      if (hit < 0 && dx * dx + dy * dy < rad * rad) hit = i;
    end
    r.action   = ACT_IGNORED;
    r.crossing = CROSS_NONE;
    if (hit >= 0) begin
      if (zone_has(b.x)) begin
        if (b.x >= cfg_line && trk_x[hit] < cfg_line) r.crossing = CROSS_RIGHT;
        else if (b.x <= cfg_line && trk_x[hit] > cfg_line) r.crossing = CROSS_LEFT;
        if (r.crossing == CROSS_RIGHT && net_total != NET_MAX) begin
          net_total = net_total + 16'sd1;
        end else if (r.crossing == CROSS_LEFT && net_total != NET_MIN) begin
          net_total = net_total - 16'sd1;
        end
        trk_x[hit] = b.x;
        trk_y[hit] = b.y;
        r.action = ACT_UPDATED;
      end else begin
        // erase and close the gap
        for (i = hit; i + 1 < int'(track_count); i++) begin
          trk_x[i] = trk_x[i + 1];
          trk_y[i] = trk_y[i + 1];
        end
        track_count--;
        r.action = ACT_DROPPED;
      end
    end else if (zone_has(b.x)) begin
      if (track_count < MAX_TRACKS) begin
        trk_x[track_count] = b.x;
        trk_y[track_count] = b.y;
        track_count++;
        r.action = ACT_ADDED;
      end else begin
        r.action = ACT_FULL;
      end
    end
    r.total  = net_total;
    r.tracks = TRK_W'(track_count);
    expected_reports.insert(expected_reports.size(), r);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    if (error_count <= 40)
      $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $time);
  endtask

  task automatic check_report(input logic [OUT_TDATA_W-1:0] word);
    count_report_t got, want;
    got = word[OUT_W-1:0];
    if (expected_reports.size() == 0) begin
      report_mismatch("result with nothing pending", word, 0);
      return;
    end
    want = expected_reports.pop_front();
    if (got.total != want.total)
      report_mismatch("people_total", $signed(got.total), $signed(want.total));
    if (got.action != want.action)
      report_mismatch("action", got.action, want.action);
    if (got.crossing != want.crossing)
      report_mismatch("crossing", $signed(got.crossing), $signed(want.crossing));
    if (got.tracks != want.tracks)
      report_mismatch("tracks_in_use", got.tracks, want.tracks);
    if (word[OUT_TDATA_W-1:OUT_W] != '0)
      report_mismatch("tdata padding", word[OUT_TDATA_W-1:OUT_W], 0);
  endtask

  task automatic send_blob(input blob_t b);
    int unsigned gap;
    gap = $urandom_range(0, src_gap_max);
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  <= b;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_tracking(b);
  endtask

  task automatic send_xywh(input int x, input int y, input int w, input int h);
    blob_t b;
    b.x          = COORD_W'(x);
    b.y          = COORD_W'(y);
    b.box_width  = BOX_W'(w);
    b.box_height = BOX_W'(h);
    send_blob(b);
  endtask

  // every result back, input side quiet and the block idle
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait (expected_reports.size() == 0);
    wait (s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [REG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_ZONE_LEFT:  cfg_left  = val;
      REG_ZONE_RIGHT: cfg_right = val;
      REG_CROSS_LINE: cfg_line  = val;
      default: ;
    endcase
  endtask

  task automatic set_zone(input int left, input int right, input int line);
    write_reg(REG_ZONE_LEFT, REG_W'(left));
    write_reg(REG_ZONE_RIGHT, REG_W'(right));
    write_reg(REG_CROSS_LINE, REG_W'(line));
  endtask

  // with an inverted zone every exact hit erases its entry
  task automatic clear_tracks();
    drain();
    set_zone(COORD_TOP, 0, cfg_line);
    while (track_count != 0) send_xywh(trk_x[0], trk_y[0], 0, 0);
    drain();
  endtask

  function automatic blob_t random_blob();
    blob_t b;
    int unsigned pick, k, stride, span;
    int dx, dy;
    b.x          = COORD_W'($urandom_range(0, COORD_TOP));
    b.y          = COORD_W'($urandom_range(0, COORD_TOP));
    b.box_width  = BOX_W'($urandom_range(0, COORD_TOP));
    b.box_height = BOX_W'($urandom_range(0, COORD_TOP));
    pick = $urandom_range(0, 99);
    if (track_count != 0 && pick < 60) begin
      // small move of a tracked blob, box wide enough to match
      k      = $urandom_range(0, track_count - 1);
      stride = $urandom_range(0, 8);
      dx     = int'($urandom_range(0, 2 * stride)) - int'(stride);
      dy     = int'($urandom_range(0, stride)) - int'(stride / 2);
      b.x          = clamp_coord(int'(trk_x[k]) + dx);
      b.y          = clamp_coord(int'(trk_y[k]) + dy);
      b.box_width  = BOX_W'($urandom_range(4 * stride + 2, 4 * stride + 50));
      b.box_height = BOX_W'($urandom_range(4 * stride + 2, 4 * stride + 50));
    end else if (track_count != 0 && pick < 68) begin
      // step just past a zone edge
      k = $urandom_range(0, track_count - 1);
      if (cfg_left != 0 && ($urandom_range(0, 1) == 1 || cfg_right == COORD_TOP))
        b.x = cfg_left - 1'b1;
      else if (cfg_right != COORD_TOP)
        b.x = cfg_right + 1'b1;
      else
        b.x = trk_x[k];
      b.y  = trk_y[k];
      span = (b.x > trk_x[k]) ? b.x - trk_x[k] : trk_x[k] - b.x;
      b.box_width  = clamp_coord(int'(2 * span + 2 + $urandom_range(0, 20)));
      b.box_height = clamp_coord(int'(2 * span + 2 + $urandom_range(0, 20)));
    end else if (cfg_left <= cfg_right && pick < 90) begin
      // fresh blob, often close to the line
      b.x = clamp_coord(int'(cfg_line) + int'($urandom_range(0, 24)) - 12);
      if (pick < 80 || !zone_has(b.x)) b.x = COORD_W'($urandom_range(cfg_left, cfg_right));
      b.box_width  = BOX_W'($urandom_range(0, 40));
      b.box_height = BOX_W'($urandom_range(0, 40));
    end
    return b;
  endfunction

  task automatic run_phase(input int left, input int right, input int line, input int n);
    drain();
    set_zone(left, right, line);
    repeat (n) send_blob(random_blob());
    drain();
  endtask

  task automatic test_crossings();
    // reset zone 40..160, line at 80
    send_xywh(70, 100, 20, 20);
    send_xywh(78, 100, 20, 20);
    send_xywh(80, 100, 20, 20);      // rightward
    send_xywh(85, 100, 20, 20);
    send_xywh(79, 100, 20, 20);      // leftward
    send_xywh(30, 100, 20, 20);      // outside the zone and too far away to match
    send_xywh(4095, 4095, 4095, 4095);
    send_xywh(0, 0, 0, 0);
    send_xywh(100, 200, 0, 0);
    send_xywh(100, 201, 1, 1);       // half-size zero, one pixel away
    send_xywh(100, 200, 0, 0);       // half-size zero, exact hit
    send_xywh(120, 300, 10, 10);
    send_xywh(39, 200, 200, 200);    // drops entry 1, the entries above it shift down
    send_xywh(150, 4095, 4095, 4095);
    drain();
  endtask

  task automatic test_full_table();
    int i;
    clear_tracks();
    set_zone(0, COORD_TOP, 2048);
    for (i = 0; i < int'(MAX_TRACKS); i++) send_xywh(i * 250 + 5, 64 + i, 0, 0);
    send_xywh(3000, 3000, 1, 1);
    send_xywh(255, 65, 3, 3);
    drain();
    set_zone(COORD_TOP, 0, 2048);
    send_xywh(1255, 69, 0, 0);       // middle entry
    send_xywh(3755, 79, 0, 0);       // last entry
    send_xywh(2000, 2000, 0, 0);
    drain();
  endtask

  task automatic test_crossing_runs();
    clear_tracks();
    set_zone(0, COORD_TOP, 2048);
    src_gap_max    = 0;
    sink_stall_max = 0;
    send_xywh(2047, 10, 4, 4);
    // step onto the line counts, stepping back off it does not
    repeat (10) begin
      send_xywh(2048, 10, 4, 4);
      send_xywh(2047, 10, 4, 4);
    end
    send_xywh(2049, 10, 4, 4);
    // leftward steps drive the count below zero
    repeat (16) begin
      send_xywh(2048, 10, 4, 4);
      send_xywh(2049, 10, 4, 4);
    end
    drain();
    src_gap_max    = 6;
    sink_stall_max = 6;
  endtask

  task automatic test_backpressure();
    drain();
    set_zone(0, COORD_TOP, 2048);
    src_gap_max = 0;
    sink_hold   = 150;
    repeat (12) send_blob(random_blob());
    drain();
    src_gap_max = 6;
  endtask

  task automatic test_random_traffic();
    int unsigned a, b;
    run_phase(ZONE_LEFT_RST, ZONE_RIGHT_RST, CROSS_LINE_RST, 40);
    run_phase(0, COORD_TOP, 2048, 40);
    src_gap_max    = 0;
    sink_stall_max = 0;
    run_phase(100, 900, 500, 40);
    src_gap_max    = 6;
    sink_stall_max = 6;
    run_phase(0, 0, 0, 30);
    run_phase(COORD_TOP, COORD_TOP, COORD_TOP, 30);
    run_phase(COORD_TOP, 0, 100, 20);
    repeat (2) begin
      a = $urandom_range(0, COORD_TOP);
      b = $urandom_range(0, COORD_TOP);
      if (a > b) run_phase(b, a, $urandom_range(b, a), 40);
      else run_phase(a, b, $urandom_range(a, b), 40);
    end
  endtask

  initial begin : report_sink
    int unsigned stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall     = $urandom_range(0, sink_stall_max) + sink_hold;
      sink_hold = 0;
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      check_report(m_axis_tdata);
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tvalid = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = REG_ZONE_LEFT;
    cfg_wdata_i   = '0;
    track_count   = 0;
    net_total     = '0;
    cfg_left      = ZONE_LEFT_RST;
    cfg_right     = ZONE_RIGHT_RST;
    cfg_line      = CROSS_LINE_RST;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_crossings();
    test_full_table();
    test_crossing_runs();
    test_backpressure();
    test_random_traffic();

    drain();
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (error_count == 0 && expected_reports.size() == 0) begin
      $display("centroid_line_crossing_counter_core verification clean");
    end else begin
      $display("centroid_line_crossing_counter_core verification failed");
    end
    $finish;
  end

  initial begin
    #300_000_000;
    $display("centroid_line_crossing_counter_core verification failed");
    $finish;
  end

endmodule

[centroid_line_crossing_counter_core.f]
hdl/clcc_pkg.sv
hdl/clcc_ram.sv
hdl/clcc_ctrl.sv
hdl/clcc_dp.sv
hdl/centroid_line_crossing_counter_core.sv
test/centroid_line_crossing_counter_core_tb.sv
